// ----- rtl/framed_record_ring_buffer_macros.svh -----
// Assertion helpers used by the checker file rtl/frb_checker.sv.
`ifndef FRAMED_RECORD_RING_BUFFER_MACROS_SVH
`define FRAMED_RECORD_RING_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRB_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/frb_pkg.sv -----
`timescale 1ns / 1ps
package frb_pkg;

  localparam int HDR_BYTES   = 20;
  localparam int SIZE_MARGIN = 1024;
  localparam int IDX_W       = 5;
  localparam int HDR_BITS    = HDR_BYTES * 8;
  localparam logic [31:0] MAGIC_RESET = 32'h1234_5678;

  typedef enum logic [2:0] {
    KIND_WBEGIN  = 3'd0,
    KIND_WBYTE   = 3'd1,
    KIND_RHDR    = 3'd2,
    KIND_RBYTE   = 3'd3,
    KIND_ADVANCE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SIZE_REJ   = 3'd1,
    ST_NO_ROOM    = 3'd2,
    ST_HDR_MISFIT = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_CORRUPT    = 3'd5,
    ST_BAD_ADV    = 3'd6,
    ST_NO_PENDING = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WBPLAN,
    S_HWRITE,
    S_HREAD,
    S_HCHECK,
    S_HCLEAR,
    S_REDUCE,
    S_RBWAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] rec_type;
    logic [15:0] rec_subtype;
    logic [7:0]  channel_in;
    logic [15:0] frame_length;
    logic [7:0]  data_in;
    logic [15:0] byte_offset;
    logic [15:0] advance_amount;
  } frb_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] type_out;
    logic [15:0] subtype_out;
    logic [7:0]  channel_out;
    logic [15:0] payload_len;
    logic [15:0] skip_len;
    logic [7:0]  data_byte;
  } frb_out_t;

  typedef struct packed {
    logic             load_in;
    logic             decode;
    logic             wb_plan;
    logic             hwrite;
    logic             hread;
    logic             hcap;
    logic             hcheck;
    logic             hclear;
    logic             reduce;
    logic             rb_cap;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } frb_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       dec_ok;
    logic       red_more;
  } frb_stat_t;

endpackage

// ----- rtl/frb_if.sv -----
`timescale 1ns / 1ps
interface frb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] rec_type;
  logic [15:0] rec_subtype;
  logic [7:0]  channel_in;
  logic [15:0] frame_length;
  logic [7:0]  data_in;
  logic [15:0] byte_offset;
  logic [15:0] advance_amount;

  modport source (output valid, kind, rec_type, rec_subtype, channel_in,
                  frame_length, data_in, byte_offset, advance_amount,
                  input ready);
  modport sink (input valid, kind, rec_type, rec_subtype, channel_in,
                frame_length, data_in, byte_offset, advance_amount,
                output ready);
endinterface

interface frb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] type_out;
  logic [15:0] subtype_out;
  logic [7:0]  channel_out;
  logic [15:0] payload_len;
  logic [15:0] skip_len;
  logic [7:0]  data_byte;

  modport source (output valid, status, type_out, subtype_out, channel_out,
                  payload_len, skip_len, data_byte, input ready);
  modport sink (input valid, status, type_out, subtype_out, channel_out,
                payload_len, skip_len, data_byte, output ready);
endinterface

// ----- rtl/frb_ram.sv -----
`timescale 1ns / 1ps
module frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/frb_ctrl.sv -----
`timescale 1ns / 1ps
module frb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  frb_pkg::frb_stat_t stat,
  output frb_pkg::frb_cmd_t  cmd
);
  import frb_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  logic             load_out;

  assign load_out  = (state_r == S_RESULT) && (!ov_r || out_ready);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_nxt = '0;
        if (!stat.dec_ok) begin
          state_nxt = S_RESULT;
        end else begin
          case (stat.kind)
            KIND_WBEGIN:  state_nxt = S_WBPLAN;
            KIND_RHDR:    state_nxt = S_HREAD;
            KIND_RBYTE:   state_nxt = S_REDUCE;
            KIND_ADVANCE: state_nxt = S_REDUCE;
            default:      state_nxt = S_RESULT;
          endcase
        end
      end
      S_WBPLAN: state_nxt = S_HWRITE;
      S_HWRITE: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(HDR_BYTES - 1)) begin
          state_nxt = S_RESULT;
        end
      end
      S_HREAD: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(HDR_BYTES)) begin
          cnt_nxt   = '0;
          state_nxt = S_HCHECK;
        end
      end
      S_HCHECK: begin
        // The clear pass runs only when the header checked out.
        if (stat.dec_ok) begin
          state_nxt = S_HCLEAR;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_HCLEAR: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(3)) begin
          state_nxt = S_RESULT;
        end
      end
      S_REDUCE: begin
        if (!stat.red_more) begin
          state_nxt = (stat.kind == KIND_RBYTE) ? S_RBWAIT : S_RESULT;
        end
      end
      S_RBWAIT: state_nxt = S_RESULT;
      S_RESULT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.idx = cnt_r;
    case (state_r)
      S_IDLE:   cmd.load_in = in_valid;
      S_DECODE: cmd.decode  = 1'b1;
      S_WBPLAN: cmd.wb_plan = 1'b1;
      S_HWRITE: cmd.hwrite  = 1'b1;
      S_HREAD: begin
        cmd.hread = (cnt_r < IDX_W'(HDR_BYTES));
        cmd.hcap  = (cnt_r != '0);
      end
      S_HCHECK: cmd.hcheck   = 1'b1;
      S_HCLEAR: cmd.hclear   = 1'b1;
      S_REDUCE: cmd.reduce   = 1'b1;
      S_RBWAIT: cmd.rb_cap   = 1'b1;
      S_RESULT: cmd.out_load = load_out;
      default:  cmd.idx      = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ----- rtl/frb_dpath.sv -----
`timescale 1ns / 1ps
module frb_dpath #(
  parameter int BUF_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  frb_pkg::frb_cmd_t  cmd,
  output frb_pkg::frb_stat_t stat,
  input  frb_pkg::frb_in_t   in_item,
  input  logic [31:0]        magic,
  output frb_pkg::frb_out_t  out_item
);
  import frb_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = ((AW > 17) ? AW : 17) + 1;
  localparam logic [CW-1:0] SIZE_C = CW'(BUF_BYTES);
  localparam logic [CW-1:0] HDR_C  = CW'(HDR_BYTES);

  frb_in_t       in_r, in_nxt;
  frb_out_t      res_r, res_nxt, out_r, out_nxt;
  logic [AW-1:0] rp_r, rp_nxt, wp_r, wp_nxt, pd_r, pd_nxt, pcp_r, pcp_nxt;
  logic [15:0]   prem_r, prem_nxt;
  logic          pact_r, pact_nxt;
  logic [CW-1:0] pad_r, pad_nxt, mod_r, mod_nxt;
  logic [HDR_BITS-1:0] hw_r, hw_nxt, hb_r, hb_nxt;

  logic [CW-1:0] rp_x, wp_x, len_x, pad_x, room_x, need_x, dbase_x, pd_inc;
  logic [CW-1:0] dd_x, cm_x, cm2_x, tail_x, pf_x, cmf_x, clen_x;
  status_t       dec_st;
  logic [31:0]   h_magic, h_dl, h_pl;
  logic [32:0]   h_span;
  logic          h_ok;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  frb_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rp_x    = CW'(rp_r);
  assign wp_x    = CW'(wp_r);
  assign len_x   = CW'(in_r.frame_length);
  assign pad_x   = (len_x + CW'(3)) & ~CW'(3);
  assign room_x  = (rp_x > wp_x) ? (rp_x - wp_x) : (SIZE_C - wp_x + rp_x);
  assign need_x  = CW'(2 * HDR_BYTES + 1) + pad_x;
  assign dbase_x = (rp_x + HDR_C >= SIZE_C) ? '0 : (rp_x + HDR_C);
  assign pd_inc  = (CW'(pd_r) + CW'(1) >= SIZE_C) ? '0 : (CW'(pd_r) + CW'(1));

  // Status of the first decode step, per kind.
  always_comb begin
    case (in_r.kind)
      KIND_WBEGIN: begin
        if ((in_r.frame_length == '0) || (len_x + CW'(SIZE_MARGIN) >= SIZE_C)) begin
          dec_st = ST_SIZE_REJ;
        end else if (need_x > room_x) begin
          dec_st = ST_NO_ROOM;
        end else if (wp_x + HDR_C > SIZE_C) begin
          dec_st = ST_HDR_MISFIT;
        end else begin
          dec_st = ST_OK;
        end
      end
      KIND_WBYTE: dec_st = pact_r ? ST_OK : ST_NO_PENDING;
      KIND_RHDR: begin
        if (rp_r == wp_r) begin
          dec_st = ST_EMPTY;
        end else if (rp_x + HDR_C > SIZE_C) begin
          dec_st = ST_CORRUPT;
        end else begin
          dec_st = ST_OK;
        end
      end
      KIND_RBYTE:   dec_st = (rp_r == wp_r) ? ST_EMPTY : ST_OK;
      KIND_ADVANCE: dec_st = (in_r.advance_amount == '0) ? ST_BAD_ADV : ST_OK;
      default:      dec_st = ST_OK;
    endcase
  end

  // Placement of a new record; a short tail past it is folded into padding.
  always_comb begin
    dd_x   = (wp_x + HDR_C >= SIZE_C) ? '0 : (wp_x + HDR_C);
    cm_x   = dd_x + pad_r;
    cm2_x  = (cm_x >= SIZE_C) ? (cm_x - SIZE_C) : cm_x;
    tail_x = SIZE_C - cm2_x;
    if (tail_x < HDR_C) begin
      pf_x  = pad_r + tail_x;
      cmf_x = '0;
    end else begin
      pf_x  = pad_r;
      cmf_x = cm2_x;
    end
  end

  assign h_magic = hb_r[31:0];
  assign h_dl    = hb_r[127:96];
  assign h_pl    = hb_r[159:128];
  assign clen_x  = (rp_x <= wp_x) ? (wp_x - rp_x) : (SIZE_C - rp_x + wp_x);
  assign h_span  = {1'b0, h_pl} + 33'(HDR_BYTES);
  assign h_ok    = (h_magic == magic) && (h_dl != '0) && (h_dl < 32'(BUF_BYTES)) &&
                   (h_dl <= h_pl) && (h_span <= 33'(clen_x));

  assign stat.kind     = in_r.kind;
  assign stat.dec_ok   = cmd.hcheck ? h_ok : (dec_st == ST_OK);
  assign stat.red_more = (mod_r >= SIZE_C);

  always_comb begin
    we    = 1'b0;
    waddr = pd_r;
    wdata = in_r.data_in;
    if (cmd.hwrite) begin
      we    = 1'b1;
      waddr = wp_r + AW'(cmd.idx);
      wdata = hw_r[7:0];
    end else if (cmd.hclear) begin
      we    = 1'b1;
      waddr = rp_r + AW'(cmd.idx);
      wdata = 8'h00;
    end else if (cmd.decode && (in_r.kind == KIND_WBYTE) && pact_r) begin
      we = 1'b1;
    end
  end

  assign raddr = cmd.hread ? (rp_r + AW'(cmd.idx)) : mod_r[AW-1:0];

  always_comb begin
    in_nxt   = in_r;
    res_nxt  = res_r;
    out_nxt  = out_r;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    pd_nxt   = pd_r;
    pcp_nxt  = pcp_r;
    prem_nxt = prem_r;
    pact_nxt = pact_r;
    pad_nxt  = pad_r;
    mod_nxt  = mod_r;
    hw_nxt   = hw_r;
    hb_nxt   = hb_r;
    if (cmd.load_in) begin
      in_nxt = in_item;
    end
    if (cmd.decode) begin
      res_nxt        = '0;
      res_nxt.status = dec_st;
      case (in_r.kind)
        KIND_WBEGIN: begin
          pact_nxt = 1'b0;
          pad_nxt  = pad_x;
        end
        KIND_WBYTE: begin
          if (pact_r) begin
            pd_nxt   = pd_inc[AW-1:0];
            prem_nxt = prem_r - 16'd1;
            if (prem_r == 16'd1) begin
              wp_nxt   = pcp_r;
              pact_nxt = 1'b0;
            end
          end
        end
        KIND_RBYTE:   mod_nxt = dbase_x + CW'(in_r.byte_offset);
        KIND_ADVANCE: mod_nxt = rp_x + CW'(in_r.advance_amount);
        default:      mod_nxt = mod_r;
      endcase
    end
    if (cmd.wb_plan) begin
      pd_nxt   = dd_x[AW-1:0];
      prem_nxt = in_r.frame_length;
      pcp_nxt  = cmf_x[AW-1:0];
      pact_nxt = 1'b1;
      hw_nxt   = {32'(pf_x), 32'(in_r.frame_length), 32'(in_r.channel_in),
                  in_r.rec_type, in_r.rec_subtype, magic};
    end
    if (cmd.hwrite) begin
      hw_nxt = hw_r >> 8;
    end
    if (cmd.hcap) begin
      hb_nxt = {rdata, hb_r[HDR_BITS-1:8]};
    end
    if (cmd.hcheck) begin
      if (h_ok) begin
        res_nxt.type_out    = hb_r[63:48];
        res_nxt.subtype_out = hb_r[47:32];
        res_nxt.channel_out = hb_r[71:64];
        res_nxt.payload_len = h_dl[15:0];
        res_nxt.skip_len    = h_span[15:0];
      end else begin
        res_nxt.status = ST_CORRUPT;
      end
    end
    if (cmd.reduce) begin
      if (mod_r >= SIZE_C) begin
        mod_nxt = mod_r - SIZE_C;
      end else if (in_r.kind == KIND_ADVANCE) begin
        rp_nxt = mod_r[AW-1:0];
      end
    end
    if (cmd.rb_cap) begin
      res_nxt.data_byte = rdata;
    end
    if (cmd.out_load) begin
      out_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      wp_r   <= '0;
      pd_r   <= '0;
      pcp_r  <= '0;
      prem_r <= '0;
      pact_r <= 1'b0;
    end else begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      pd_r   <= pd_nxt;
      pcp_r  <= pcp_nxt;
      prem_r <= prem_nxt;
      pact_r <= pact_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    pad_r <= pad_nxt;
    mod_r <= mod_nxt;
    hw_r  <= hw_nxt;
    hb_r  <= hb_nxt;
  end

  assign out_item = out_r;

endmodule

// ----- rtl/framed_record_ring_buffer.sv -----
`timescale 1ns / 1ps
// Byte ring buffer of BUF_BYTES entries holding framed records, one result
// transaction per input transaction. Items are handled one at a time through a
// single-port-write, single-port-read byte memory: write_byte, unused kinds
// and items rejected at decode pass through accept, decode and result;
// advance passes through accept, decode, reduction with pointer update and result;
// write_begin adds a planning step and the 20 header byte writes; read_header
// adds 20 header byte reads, a header check and 4 byte writes to clear the
// magic, skipping the clear when the header fails its check after the read;
// read_byte adds a read wait after its reduction, and read_byte and advance
// repeat the reduction while the address sum is at or above BUF_BYTES. A
// new transaction is accepted while the previous result still waits at the
// output register. The memory needs no clearing pass after reset.
module framed_record_ring_buffer #(
  parameter int BUF_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  frb_in_if.sink      in_ch,
  frb_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import frb_pkg::*;

  frb_cmd_t    cmd;
  frb_stat_t   stat;
  frb_in_t     in_item;
  frb_out_t    out_item;
  logic [31:0] magic_r, magic_nxt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign magic_nxt  = cfg_wr ? cfg_pwdata : magic_r;
  assign cfg_prdata = cfg_paddr[2] ? 32'h0 : magic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else begin
      magic_r <= magic_nxt;
    end
  end

  assign in_item.kind           = in_ch.kind;
  assign in_item.rec_type       = in_ch.rec_type;
  assign in_item.rec_subtype    = in_ch.rec_subtype;
  assign in_item.channel_in     = in_ch.channel_in;
  assign in_item.frame_length   = in_ch.frame_length;
  assign in_item.data_in        = in_ch.data_in;
  assign in_item.byte_offset    = in_ch.byte_offset;
  assign in_item.advance_amount = in_ch.advance_amount;

  assign out_ch.status      = out_item.status;
  assign out_ch.type_out    = out_item.type_out;
  assign out_ch.subtype_out = out_item.subtype_out;
  assign out_ch.channel_out = out_item.channel_out;
  assign out_ch.payload_len = out_item.payload_len;
  assign out_ch.skip_len    = out_item.skip_len;
  assign out_ch.data_byte   = out_item.data_byte;

  frb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frb_dpath #(.BUF_BYTES(BUF_BYTES)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .magic    (magic_r),
    .out_item (out_item)
  );

endmodule

// ----- rtl/frb_checker.sv -----
`timescale 1ns / 1ps
`include "framed_record_ring_buffer_macros.svh"
module frb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_payload_len,
  input logic [15:0] out_skip_len,
  input logic [7:0]  out_data_byte
);
  import frb_pkg::*;

  `FRB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `FRB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "second transaction taken while busy")
  `FRB_ASSERT_NOW(a_err_fields_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_payload_len == 16'h0) && (out_data_byte == 8'h0), "error result carries data")
  `FRB_ASSERT_NOW(a_hdr_consistent, clk, rst_n, out_valid && (out_skip_len != 16'h0), (out_status == ST_OK) && (out_payload_len != 16'h0), "header result inconsistent")

endmodule

bind framed_record_ring_buffer frb_checker u_frb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_payload_len (out_ch.payload_len),
  .out_skip_len    (out_ch.skip_len),
  .out_data_byte   (out_ch.data_byte)
);
